[sv/mf33_pkg.sv]
// ----------------------------------------------------------------------------
// mf33_pkg
// Types, constants and sorting-network helpers for the 3x3 RGB median filter.
// ----------------------------------------------------------------------------
package mf33_pkg;

	localparam int LS_W       = 48;
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = 4;

	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	localparam logic [10:0] WIDTH_RST  = 11'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;

	typedef logic [7:0]        smp_t;
	typedef logic [8:0][7:0]   win9_t;
	typedef logic [8:0][23:0]  pix9_t;

	typedef struct packed {
		logic [11:0] row;
		logic [9:0]  col;
		logic        frame_end;
		logic        run_end;
	} meta_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] row;
		logic [9:0]  col;
		logic        frame_end;
		logic        run_end;
	} res_t;

	function automatic win9_t cs(win9_t p, int a, int b);
		win9_t q;
		q = p;
		if (p[a] > p[b]) begin
			q[a] = p[b];
			q[b] = p[a];
		end
		return q;
	endfunction

	function automatic win9_t net_a(win9_t p);
		win9_t q;
		q = cs(p, 1, 2); q = cs(q, 4, 5); q = cs(q, 7, 8);
		q = cs(q, 0, 1); q = cs(q, 3, 4); q = cs(q, 6, 7);
		q = cs(q, 1, 2); q = cs(q, 4, 5); q = cs(q, 7, 8);
		return q;
	endfunction

	function automatic win9_t net_b(win9_t p);
		win9_t q;
		q = cs(p, 0, 3); q = cs(q, 5, 8); q = cs(q, 4, 7);
		q = cs(q, 3, 6); q = cs(q, 1, 4); q = cs(q, 2, 5);
		q = cs(q, 4, 7);
		return q;
	endfunction

	function automatic smp_t net_c(win9_t p);
		win9_t q;
		q = cs(p, 4, 2); q = cs(q, 6, 4); q = cs(q, 4, 2);
		return q[4];
	endfunction

	function automatic logic [8:0] mask9(logic top, logic bot, logic left, logic right);
		logic [2:0] rok;
		logic [2:0] cok;
		logic [8:0] m;
		rok = {bot, 1'b1, top};
		cok = {right, 1'b1, left};
		for (int y = 0; y < 3; y++) begin
			for (int x = 0; x < 3; x++) begin
				m[y*3+x] = rok[y] & cok[x];
			end
		end
		return m;
	endfunction

	// pick which empty slots hold 0 so that slot 4 of the sorted nine is the set's count/2
	function automatic logic [8:0] pad_lo(logic [8:0] vld);
		logic [3:0] n;
		logic [2:0] p;
		logic [2:0] k;
		logic [8:0] lo;
		n = 4'($countones(vld));
		p = 3'd4 - 3'(n >> 1);
		k = '0;
		for (int i = 0; i < 9; i++) begin
			lo[i] = 1'b0;
			if (!vld[i] && k < p) begin
				lo[i] = 1'b1;
				k = k + 3'd1;
			end
		end
		return lo;
	endfunction

endpackage

[sv/mf33_if.sv]
// ----------------------------------------------------------------------------
// mf33 channel interfaces
// Pixel input channel and median result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mf33_pix_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source(output valid, kind, red_in, green_in, blue_in, input ready);
	modport sink(input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface mf33_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [11:0] out_row;
	logic [9:0]  out_col;
	logic        frame_end;
	logic        run_end;

	modport source(output valid, red_out, green_out, blue_out, out_row, out_col,
		frame_end, run_end, input ready);
	modport sink(input valid, red_out, green_out, blue_out, out_row, out_col,
		frame_end, run_end, output ready);
endinterface

[sv/mf33_line_store.sv]
// ----------------------------------------------------------------------------
// mf33_line_store
// Two-line pixel store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mf33_line_store
	import mf33_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  logic [LS_W-1:0] wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr_a,
	input  logic [AW-1:0]   raddr_b,
	output logic [LS_W-1:0] rdata_a,
	output logic [LS_W-1:0] rdata_b
);

	logic [LS_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[sv/mf33_med9.sv]
// ----------------------------------------------------------------------------
// mf33_med9
// Three-stage median-of-nine network, one per color channel.
// ----------------------------------------------------------------------------
module mf33_med9
	import mf33_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  pix9_t in_pix,
	input  meta_t in_meta,
	output logic  out_valid,
	output res_t  out_res
);

	win9_t ch_in [3];
	win9_t a_s1  [3];
	win9_t b_s2  [3];
	smp_t  med_s3 [3];
	logic  v_s1, v_s2, v_s3;
	meta_t meta_s1, meta_s2, meta_s3;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 9; i++) begin
				ch_in[ch][i] = in_pix[i][23-8*ch -: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			a_s1[ch]   <= net_a(ch_in[ch]);
			b_s2[ch]   <= net_b(a_s1[ch]);
			med_s3[ch] <= net_c(b_s2[ch]);
		end
		meta_s1 <= in_meta;
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
	end

	assign out_valid = v_s3;
	assign out_res   = '{red: med_s3[0], green: med_s3[1], blue: med_s3[2],
		row: meta_s3.row, col: meta_s3.col, frame_end: meta_s3.frame_end,
		run_end: meta_s3.run_end};

endmodule

[sv/mf33_out_fifo.sv]
// ----------------------------------------------------------------------------
// mf33_out_fifo
// Result queue taking up to two items per cycle, one out per cycle.
// ----------------------------------------------------------------------------
module mf33_out_fifo
	import mf33_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_a,
	input  res_t data_a,
	input  logic wr_b,
	input  res_t data_b,
	input  logic pop,
	output logic valid,
	output res_t head
);

	res_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW:0]   wp_q, rp_q;
	logic [FIFO_AW:0]   wp_b;

	assign wp_b  = wr_a ? wp_q + (FIFO_AW+1)'(1) : wp_q;
	assign valid = wp_q != rp_q;
	assign head  = fifo_q[rp_q[FIFO_AW-1:0]];

	always_ff @(posedge clk) begin
		if (wr_a) begin
			fifo_q[wp_q[FIFO_AW-1:0]] <= data_a;
		end
		if (wr_b) begin
			fifo_q[wp_b[FIFO_AW-1:0]] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			wp_q <= wp_q + (FIFO_AW+1)'(wr_a) + (FIFO_AW+1)'(wr_b);
			rp_q <= rp_q + (FIFO_AW+1)'(pop);
		end
	end

endmodule

[sv/median_filter_3x3_rgb_core.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb_core
// 3x3 per-channel median over a raster RGB stream, border-aware.
// Path: input register and line-store read, window register, median network,
// result queue. Throughput: one item per cycle while pixel.ready is high;
// a row-end item gives two results, leaving in turn via the one output port.
// Reset: counters, drain flag and sizes (640x480) reset; line store unset.
// ----------------------------------------------------------------------------
module median_filter_3x3_rgb_core
	import mf33_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	mf33_pix_if.sink    pixel,
	mf33_res_if.source  result
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [10:0]   width_q;
	logic [12:0]   height_q;
	logic [CW-1:0] wm1;
	logic [RW-1:0] hm1;

	logic [CW-1:0] ic_q, oc_q;
	logic [RW-1:0] ir_q;
	logic          drain_q;
	logic [FIFO_AW:0] pend_q;

	logic          acc, acc_pix, acc_drn, vA, vB, pop;
	logic [1:0]    nres;
	logic [RW-1:0] row_p, rA;
	logic [CW-1:0] cA, colm1;
	logic          topA, botA, leftA, rightA;
	logic [8:0]    vldA, vldB;
	meta_t         metaA, metaB;
	logic [CW-1:0] raddr_a, raddr_b;

	logic [LS_W-1:0] rd_a, rd_b, ra, rb, wdata;

	logic            pix_s1, drn_s1, vA_s1, vB_s1, fa_s1, fb_s1;
	logic [CW-1:0]   wa_s1;
	logic [23:0]     px_s1;
	logic [LS_W-1:0] fd_s1;
	logic [8:0]      vldA_s1, loA_s1, vldB_s1, loB_s1;
	meta_t           metaA_s1, metaB_s1;

	logic [23:0]     win_q [3][3];
	logic [LS_W-1:0] dprev_q;
	logic [23:0]     newcol [3];
	pix9_t           pA, pB;

	logic  vA_s2, vB_s2;
	pix9_t pA_s2, pB_s2;
	meta_t metaA_s2, metaB_s2;

	logic  oA_valid, oB_valid, q_valid;
	res_t  oA, oB, q_head;

	always_comb begin
		if (width_q == '0) begin
			wm1 = '0;
		end else if (int'(width_q) > MAX_WIDTH) begin
			wm1 = CW'(MAX_WIDTH - 1);
		end else begin
			wm1 = CW'(width_q - 11'd1);
		end
		if (height_q == '0) begin
			hm1 = '0;
		end else if (int'(height_q) > MAX_HEIGHT) begin
			hm1 = RW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = RW'(height_q - 13'd1);
		end
	end

	assign acc     = pixel.valid && pixel.ready;
	assign acc_pix = acc && !pixel.kind;
	assign acc_drn = acc && pixel.kind && drain_q;
	assign pixel.ready = pend_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2);

	assign row_p = ir_q - RW'(1);
	assign colm1 = ic_q - CW'(1);
	assign vA    = acc_pix ? (ir_q != '0 && ic_q != '0) : acc_drn;
	assign vB    = acc_pix && ir_q != '0 && ic_q == wm1;
	assign nres  = {1'b0, vA} + {1'b0, vB};

	always_comb begin
		if (pixel.kind) begin
			rA     = hm1;
			cA     = oc_q;
			topA   = hm1 != '0;
			botA   = 1'b0;
		end else begin
			rA     = row_p;
			cA     = colm1;
			topA   = row_p != '0;
			botA   = row_p != hm1;
		end
		leftA  = cA != '0;
		rightA = cA != wm1;
		vldA   = mask9(topA, botA, leftA, rightA);
		vldB   = mask9(row_p != '0, row_p != hm1, ic_q != '0, ic_q != wm1);
		metaA  = '{row: 12'(rA), col: 10'(cA),
			frame_end: (rA == hm1) && (cA == wm1), run_end: !vB};
		metaB  = '{row: 12'(row_p), col: 10'(ic_q),
			frame_end: (row_p == hm1) && (ic_q == wm1), run_end: 1'b1};
	end

	assign raddr_a = pixel.kind ? oc_q : ic_q;
	assign raddr_b = raddr_a + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			ic_q     <= '0;
			ir_q     <= '0;
			oc_q     <= '0;
			drain_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_IDX_WIDTH:  width_q  <= cfg_data[10:0];
				CFG_IDX_HEIGHT: height_q <= cfg_data;
			endcase
			ic_q    <= '0;
			ir_q    <= '0;
			oc_q    <= '0;
			drain_q <= 1'b0;
		end else if (acc_pix) begin
			drain_q <= (ic_q == wm1) && (ir_q == hm1);
			if (ic_q == wm1) begin
				ic_q <= '0;
				if (ir_q == hm1) begin
					ir_q <= '0;
					oc_q <= '0;
				end else begin
					ir_q <= ir_q + RW'(1);
				end
			end else begin
				ic_q <= ic_q + CW'(1);
			end
		end else if (acc_drn) begin
			if (oc_q == wm1) begin
				oc_q    <= '0;
				drain_q <= 1'b0;
			end else begin
				oc_q <= oc_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + (FIFO_AW+1)'(nres) - (FIFO_AW+1)'(pop);
		end
	end

	mf33_line_store #(
		.DEPTH(MAX_WIDTH),
		.AW   (CW)
	) u_store (
		.clk    (clk),
		.we     (pix_s1),
		.waddr  (wa_s1),
		.wdata  (wdata),
		.re     (acc),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= 1'b0;
			drn_s1 <= 1'b0;
			vA_s1  <= 1'b0;
			vB_s1  <= 1'b0;
		end else begin
			pix_s1 <= acc_pix;
			drn_s1 <= acc_drn;
			vA_s1  <= vA;
			vB_s1  <= vB;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			wa_s1    <= raddr_a;
			px_s1    <= {pixel.red_in, pixel.green_in, pixel.blue_in};
			fa_s1    <= pix_s1 && wa_s1 == raddr_a;
			fb_s1    <= pix_s1 && wa_s1 == raddr_b;
			fd_s1    <= wdata;
			vldA_s1  <= vldA;
			loA_s1   <= pad_lo(vldA);
			vldB_s1  <= vldB;
			loB_s1   <= pad_lo(vldB);
			metaA_s1 <= metaA;
			metaB_s1 <= metaB;
		end
	end

	assign ra    = fa_s1 ? fd_s1 : rd_a;
	assign rb    = fb_s1 ? fd_s1 : rd_b;
	assign wdata = {ra[23:0], px_s1};

	always_comb begin
		newcol[0] = ra[47:24];
		newcol[1] = ra[23:0];
		newcol[2] = px_s1;
		for (int y = 0; y < 3; y++) begin
			pA[y*3+0] = win_q[y][1];
			pA[y*3+1] = win_q[y][2];
			pA[y*3+2] = newcol[y];
			pB[y*3+0] = win_q[y][2];
			pB[y*3+1] = newcol[y];
			pB[y*3+2] = newcol[y];
		end
		if (drn_s1) begin
			pA[0] = dprev_q[47:24];
			pA[1] = ra[47:24];
			pA[2] = rb[47:24];
			pA[3] = dprev_q[23:0];
			pA[4] = ra[23:0];
			pA[5] = rb[23:0];
			pA[6] = '0;
			pA[7] = '0;
			pA[8] = '0;
		end
		for (int i = 0; i < 9; i++) begin
			if (!vldA_s1[i]) begin
				pA[i] = loA_s1[i] ? 24'h000000 : 24'hFFFFFF;
			end
			if (!vldB_s1[i]) begin
				pB[i] = loB_s1[i] ? 24'h000000 : 24'hFFFFFF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_s1) begin
			for (int y = 0; y < 3; y++) begin
				win_q[y][0] <= win_q[y][1];
				win_q[y][1] <= win_q[y][2];
				win_q[y][2] <= newcol[y];
			end
		end
		if (drn_s1) begin
			dprev_q <= ra;
		end
		pA_s2    <= pA;
		pB_s2    <= pB;
		metaA_s2 <= metaA_s1;
		metaB_s2 <= metaB_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vA_s2 <= 1'b0;
			vB_s2 <= 1'b0;
		end else begin
			vA_s2 <= vA_s1;
			vB_s2 <= vB_s1;
		end
	end

	mf33_med9 u_med_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vA_s2),
		.in_pix   (pA_s2),
		.in_meta  (metaA_s2),
		.out_valid(oA_valid),
		.out_res  (oA)
	);

	mf33_med9 u_med_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vB_s2),
		.in_pix   (pB_s2),
		.in_meta  (metaB_s2),
		.out_valid(oB_valid),
		.out_res  (oB)
	);

	assign pop = result.valid && result.ready;

	mf33_out_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_a  (oA_valid),
		.data_a(oA),
		.wr_b  (oB_valid),
		.data_b(oB),
		.pop   (pop),
		.valid (q_valid),
		.head  (q_head)
	);

	assign result.valid     = q_valid;
	assign result.red_out   = q_head.red;
	assign result.green_out = q_head.green;
	assign result.blue_out  = q_head.blue;
	assign result.out_row   = q_head.row;
	assign result.out_col   = q_head.col;
	assign result.frame_end = q_head.frame_end;
	assign result.run_end   = q_head.run_end;

endmodule
